>>> sv/scr_pkg.sv
// Package with shared types, codes and constants of the sparse counter store.
package scr_pkg;

    localparam int Entries  = 256;
    localparam int IdxW     = $clog2(Entries);
    localparam int CntW     = $clog2(Entries + 1);
    localparam int KeyBits  = 32;
    localparam int RegW     = 31;
    localparam logic signed [31:0] OneQ = 32'sh0001_0000;

    typedef enum logic [3:0] {
        OP_GET      = 4'd0,
        OP_SET      = 4'd1,
        OP_DEL      = 4'd2,
        OP_SET_INC  = 4'd3,
        OP_INC_CAP  = 4'd4,
        OP_INC      = 4'd5,
        OP_DEC_DEL  = 4'd6,
        OP_DECAY    = 4'd7,
        OP_DECAY_CAP = 4'd8,
        OP_SINK     = 4'd9,
        OP_COUNT    = 4'd10
    } op_t;

    typedef enum logic [1:0] {
        REG_INCREMENT = 2'd0,
        REG_DECREMENT = 2'd1,
        REG_TOP       = 2'd2
    } reg_idx_t;

    // Saturate a 34-bit signed sum to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        hi = 34'sh0_7FFF_FFFF;
        lo = -34'sh0_8000_0000;
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

>>> sv/sparse_counter_ram_core.sv
// Top level of the sparse counter store: entry memory, scan sequencer and stream ports.
// Sequence: each item runs a key scan over all entries, a read, an update and the output
// state; decay and sink add a read-and-write sweep over all entries after the scan.
// Issue: one transaction at a time, set by the one memory read port and shared adder.
// Reset: synchronous active-low aresetn clears valid bits and entry count and presets
// the config registers; memory contents are not reset.
module sparse_counter_ram_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // op[3:0], key[35:4], value[67:36], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // result_value[31:0], found[32], overflow[33],
                                   // entry_count[42:34], zero fill
);
    import scr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_FIND, ST_SWEEP_RD, ST_SWEEP_WR, ST_RD, ST_APPLY, ST_OUT
    } state_t;

    // Entry memory and valid bits.
    logic [KeyBits-1:0]       key_mem [Entries];
    logic signed [31:0]       val_mem [Entries];
    logic [Entries-1:0]       valid_reg;

    logic [RegW-1:0] inc_reg, dec_reg, top_reg;
    state_t          state_reg;
    op_t             op_reg;
    logic [KeyBits-1:0] key_reg;
    logic signed [31:0] value_reg;
    logic [IdxW:0]   scan_reg;
    logic [IdxW-1:0] slot_reg, free_reg;
    logic            found_reg, has_free_reg;
    logic [CntW-1:0] count_reg;
    logic [KeyBits-1:0] rd_key_reg;
    logic signed [31:0] rd_val_reg;
    logic [IdxW-1:0] rd_idx_reg;
    logic            rd_ok_reg;
    logic signed [31:0] res_reg;
    logic            ovf_reg;
    logic [47:0]     out_word;

    // Shared compare and add unit.
    logic signed [33:0] add_a, add_b, add_sum;
    assign add_sum = add_a + add_b;
    logic key_eq;
    assign key_eq = (rd_key_reg == key_reg);

    logic [IdxW-1:0] scan_idx;
    assign scan_idx = scan_reg[IdxW-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = out_word;

    logic sweep_sink;
    assign sweep_sink = (op_reg == OP_SINK);

    // Operand selection for the shared adder.
    always_comb begin
        add_a = 34'(rd_val_reg);
        add_b = '0;
        unique case (state_reg)
            ST_SWEEP_WR: add_b = sweep_sink ? -34'(OneQ) : -$signed({3'b0, dec_reg});
            ST_APPLY: begin
                unique case (op_reg)
                    OP_SET_INC, OP_DECAY, OP_DECAY_CAP: add_b = $signed({3'b0, inc_reg});
                    OP_INC_CAP, OP_INC: add_b = 34'(OneQ);
                    OP_DEC_DEL: add_b = -$signed({3'b0, dec_reg});
                    default: add_b = '0;
                endcase
            end
            default: add_b = '0;
        endcase
    end

    // Memory read port.
    always_ff @(posedge aclk) begin
        rd_key_reg <= key_mem[(state_reg == ST_RD) ? slot_reg : scan_idx];
        rd_val_reg <= val_mem[(state_reg == ST_RD) ? slot_reg : scan_idx];
        rd_idx_reg <= (state_reg == ST_RD) ? slot_reg : scan_idx;
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        logic signed [31:0] nv;
        logic signed [31:0] res;
        logic ins, del, wr, ovf;
        nv = '0; res = '0; ins = 1'b0; del = 1'b0; wr = 1'b0; ovf = 1'b0;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            count_reg <= '0;
            inc_reg   <= RegW'(32'h10000);
            dec_reg   <= RegW'(32'h10000);
            top_reg   <= '1;
            rd_ok_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_INCREMENT: inc_reg <= cfg_wdata;
                    REG_DECREMENT: dec_reg <= cfg_wdata;
                    REG_TOP:       top_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg       <= op_t'(s_tdata[3:0]);
                        key_reg      <= s_tdata[35:4];
                        value_reg    <= s_tdata[67:36];
                        scan_reg     <= '0;
                        found_reg    <= 1'b0;
                        has_free_reg <= 1'b0;
                        rd_ok_reg    <= 1'b0;
                        state_reg    <= ST_FIND;
                    end
                end
                // One slot per cycle: find key and lowest free slot.
                ST_FIND: begin
                    if (rd_ok_reg) begin
                        if (valid_reg[rd_idx_reg] && key_eq && !found_reg) begin
                            found_reg <= 1'b1;
                            slot_reg  <= rd_idx_reg;
                        end
                        if (!valid_reg[rd_idx_reg] && !has_free_reg) begin
                            has_free_reg <= 1'b1;
                            free_reg     <= rd_idx_reg;
                        end
                    end
                    if (scan_reg == (IdxW+1)'(Entries)) begin
                        rd_ok_reg <= 1'b0;
                        scan_reg  <= '0;
                        state_reg <= (op_reg == OP_DECAY || op_reg == OP_DECAY_CAP
                                      || op_reg == OP_SINK) ? ST_SWEEP_RD : ST_RD;
                    end else begin
                        rd_ok_reg <= 1'b1;
                        scan_reg  <= scan_reg + 1'b1;
                    end
                end
                ST_SWEEP_RD: state_reg <= ST_SWEEP_WR;
                // Decay or sink one entry; a freed slot may become the lowest free one.
                ST_SWEEP_WR: begin
                    if (valid_reg[rd_idx_reg] && (sweep_sink || !key_eq)) begin
                        if (sweep_sink ? (rd_val_reg <= OneQ) : (add_sum < 34'(OneQ))) begin
                            valid_reg[rd_idx_reg] <= 1'b0;
                            count_reg <= count_reg - 1'b1;
                            if (!has_free_reg || rd_idx_reg < free_reg) begin
                                has_free_reg <= 1'b1;
                                free_reg     <= rd_idx_reg;
                            end
                        end else begin
                            val_mem[rd_idx_reg] <= add_sum[31:0];
                        end
                    end
                    if (scan_reg == (IdxW+1)'(Entries - 1)) begin
                        state_reg <= ST_RD;
                    end else begin
                        scan_reg  <= scan_reg + 1'b1;
                        state_reg <= ST_SWEEP_RD;
                    end
                end
                ST_RD: state_reg <= ST_APPLY;
                ST_APPLY: begin
                    unique case (op_reg)
                        OP_GET: if (found_reg) res = rd_val_reg;
                        OP_SET: begin
                            if (found_reg) begin
                                res = value_reg;
                                if (value_reg == 0) del = 1'b1;
                                else begin nv = value_reg; wr = 1'b1; end
                            end else if (value_reg != 0) begin
                                nv = value_reg; ins = 1'b1;
                            end
                        end
                        OP_DEL: del = found_reg;
                        OP_SET_INC: begin
                            if (found_reg) begin nv = sat32(add_sum); wr = 1'b1; end
                            else begin nv = value_reg; ins = 1'b1; end
                        end
                        OP_INC_CAP, OP_INC: begin
                            if (found_reg) begin
                                if (op_reg == OP_INC) nv = sat32(add_sum);
                                else if (add_sum < $signed({3'b0, top_reg})) nv = add_sum[31:0];
                                else nv = rd_val_reg;
                                wr = 1'b1;
                            end else begin nv = OneQ; ins = 1'b1; end
                        end
                        OP_DEC_DEL: begin
                            if (found_reg) begin
                                if (add_sum <= 0) del = 1'b1;
                                else begin nv = add_sum[31:0]; wr = 1'b1; end
                            end
                        end
                        OP_DECAY, OP_DECAY_CAP: begin
                            if (found_reg) begin
                                nv = sat32(add_sum); wr = 1'b1;
                                if (op_reg == OP_DECAY_CAP && nv > $signed({1'b0, top_reg}))
                                    nv = $signed({1'b0, top_reg});
                            end else begin
                                nv = $signed({1'b0, inc_reg}); ins = 1'b1;
                                if (op_reg == OP_DECAY_CAP && inc_reg > top_reg)
                                    nv = $signed({1'b0, top_reg});
                            end
                        end
                        OP_SINK: if (found_reg && valid_reg[slot_reg]) res = rd_val_reg;
                        default: ;
                    endcase
                    if (wr) begin
                        val_mem[slot_reg] <= nv;
                        res = nv;
                    end
                    if (del) begin
                        valid_reg[slot_reg] <= 1'b0;
                        count_reg <= count_reg - 1'b1;
                    end
                    if (ins) begin
                        if (has_free_reg) begin
                            key_mem[free_reg]   <= key_reg;
                            val_mem[free_reg]   <= nv;
                            valid_reg[free_reg] <= 1'b1;
                            count_reg <= count_reg + 1'b1;
                            res = nv;
                        end else begin
                            ovf = 1'b1;
                        end
                    end
                    res_reg   <= res;
                    ovf_reg   <= ovf;
                    state_reg <= ST_OUT;
                end
                ST_OUT: if (m_tready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        out_word = '0;
        out_word[31:0]  = res_reg;
        out_word[32]    = found_reg;
        out_word[33]    = ovf_reg;
        out_word[42:34] = count_reg;
    end

endmodule

>>> sv/scr_checker.sv
// Port-level checker for the sparse counter store, bound to the top level.
module scr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);
    // A pending result keeps its payload until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result changed");
    // Input and output are never both open.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("ready while result pending");
    // An accepted item blocks the input next cycle.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("ready after accept");
    // Entry count never exceeds capacity.
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[42:34] <= 9'd256) else $error("count too large");
endmodule

bind sparse_counter_ram_core scr_checker u_scr_checker (.*);
